// File: hw/rtl/nrps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search package
// Sizes, request and result codes, and the command and status words that
// join the point search controller and datapath.
// ----------------------------------------------------------------------------
package nrps_pkg;

   localparam int NODE_CAPACITY = 32;
   localparam int COORD_BITS    = 16;
   localparam int IDX_W         = 6;
   localparam int ADDR_W        = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;
   localparam int SQR_W         = 2 * COORD_BITS;
   localparam int SQ_W          = 2 * COORD_BITS + 1;
   localparam int DIST_W        = 33;
   localparam int KIND_W        = 3;
   localparam int REQ_W         = 2;

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_CLEARED  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEAREST  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_WITHIN   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd5;

   typedef struct packed {
      logic              accept;
      logic              do_clear;
      logic              do_insert;
      logic              issue;
      logic [IDX_W-1:0]  issue_idx;
      logic              pass2;
      logic              emit;
      logic [KIND_W-1:0] emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_type;
      logic [IDX_W-1:0] count;
      logic             empty;
      logic             full;
      logic             out_free;
      logic             pipe_busy;
      logic             any_match;
      logic             stall;
   } dp_status_type;

endpackage

// File: hw/rtl/nrps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface nrps_req_if import nrps_pkg::*; ();

   logic                  valid;
   logic                  ready;
   logic [REQ_W-1:0]      req_type;
   logic [COORD_BITS-1:0] point_x;
   logic [COORD_BITS-1:0] point_y;
   logic [COORD_BITS-1:0] search_radius;

   modport source (output valid, output req_type, output point_x, output point_y,
                   output search_radius, input ready);
   modport sink (input valid, input req_type, input point_x, input point_y,
                 input search_radius, output ready);

endinterface

// File: hw/rtl/nrps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface nrps_rsp_if import nrps_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [IDX_W-1:0]  node_index;
   logic [DIST_W-1:0] sq_distance;
   logic              last;

   modport source (output valid, output result_kind, output node_index,
                   output sq_distance, output last, input ready);
   modport sink (input valid, input result_kind, input node_index,
                 input sq_distance, input last, output ready);

endinterface

// File: hw/rtl/nrps_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search datapath
// Point memory, request latch, pipelined squared distance unit, nearest and
// last-match tracking, and the result word register.
// ----------------------------------------------------------------------------
module nrps_datapath import nrps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [COORD_BITS-1:0] point_x,
   input  logic [COORD_BITS-1:0] point_y,
   input  logic [COORD_BITS-1:0] search_radius,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [IDX_W-1:0]      rsp_index,
   output logic [DIST_W-1:0]     rsp_dist,
   output logic                  rsp_last
);

   function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                     input logic [COORD_BITS-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   logic [COORD_BITS-1:0] mem_x [NODE_CAPACITY];
   logic [COORD_BITS-1:0] mem_y [NODE_CAPACITY];

   logic [REQ_W-1:0]      type_ff;
   logic [COORD_BITS-1:0] qx_ff;
   logic [COORD_BITS-1:0] qy_ff;
   logic [SQR_W-1:0]      rsq_ff;
   logic [IDX_W-1:0]      count_ff;

   logic                  s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff;
   logic [IDX_W-1:0]      s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [COORD_BITS-1:0] s1_x_ff, s1_y_ff, s2_dx_ff, s2_dy_ff;
   logic [SQR_W-1:0]      s3_px_ff, s3_py_ff;
   logic [SQ_W-1:0]       s4_d_ff;

   logic [SQ_W-1:0]       best_d_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [IDX_W-1:0]      last_match_ff;
   logic                  any_match_ff;

   logic                  out_vld_ff;
   logic [KIND_W-1:0]     out_kind_ff;
   logic [IDX_W-1:0]      out_idx_ff;
   logic [DIST_W-1:0]     out_dist_ff;
   logic                  out_last_ff;

   logic                  out_free;
   logic                  match;
   logic                  stall;
   logic                  en;
   logic                  within_load;

   assign out_free    = !out_vld_ff || rsp_ready;
   assign match       = (s4_d_ff <= SQ_W'(rsq_ff));
   assign stall       = s4_vld_ff && cmd.pass2 && match && !out_free;
   assign en          = !stall;
   assign within_load = s4_vld_ff && cmd.pass2 && match && out_free;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_type;
         qx_ff   <= point_x;
         qy_ff   <= point_y;
         rsq_ff  <= SQR_W'(search_radius) * SQR_W'(search_radius);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.do_clear) begin
         count_ff <= '0;
      end else if (cmd.do_insert) begin
         count_ff <= count_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_insert) begin
         mem_x[count_ff[ADDR_W-1:0]] <= qx_ff;
         mem_y[count_ff[ADDR_W-1:0]] <= qy_ff;
      end
      if (en && cmd.issue) begin
         s1_x_ff <= mem_x[cmd.issue_idx[ADDR_W-1:0]];
         s1_y_ff <= mem_y[cmd.issue_idx[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= cmd.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_idx_ff <= cmd.issue_idx;
         s2_idx_ff <= s1_idx_ff;
         s2_dx_ff  <= absdiff(qx_ff, s1_x_ff);
         s2_dy_ff  <= absdiff(qy_ff, s1_y_ff);
         s3_idx_ff <= s2_idx_ff;
         s3_px_ff  <= SQR_W'(s2_dx_ff) * SQR_W'(s2_dx_ff);
         s3_py_ff  <= SQR_W'(s2_dy_ff) * SQR_W'(s2_dy_ff);
         s4_idx_ff <= s3_idx_ff;
         s4_d_ff   <= SQ_W'(s3_px_ff) + SQ_W'(s3_py_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_match_ff <= 1'b0;
      end else if (cmd.accept) begin
         any_match_ff <= 1'b0;
      end else if (s4_vld_ff && !cmd.pass2 && match) begin
         any_match_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_vld_ff && !cmd.pass2) begin
         if ((s4_idx_ff == '0) || (s4_d_ff < best_d_ff)) begin
            best_d_ff   <= s4_d_ff;
            best_idx_ff <= s4_idx_ff;
         end
         if (match) begin
            last_match_ff <= s4_idx_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (cmd.emit || within_load) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff <= cmd.emit_kind;
         case (cmd.emit_kind)
            KIND_INSERTED: begin
               out_idx_ff  <= count_ff;
               out_dist_ff <= '0;
               out_last_ff <= 1'b1;
            end
            KIND_NEAREST: begin
               out_idx_ff  <= best_idx_ff;
               out_dist_ff <= DIST_W'(best_d_ff);
               out_last_ff <= !any_match_ff;
            end
            default: begin
               out_idx_ff  <= '0;
               out_dist_ff <= '0;
               out_last_ff <= 1'b1;
            end
         endcase
      end else if (within_load) begin
         out_kind_ff <= KIND_WITHIN;
         out_idx_ff  <= s4_idx_ff;
         out_dist_ff <= DIST_W'(s4_d_ff);
         out_last_ff <= (s4_idx_ff == last_match_ff);
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_index = out_idx_ff;
   assign rsp_dist  = out_dist_ff;
   assign rsp_last  = out_last_ff;

   always_comb begin
      status.req_type  = type_ff;
      status.count     = count_ff;
      status.empty     = (count_ff == '0);
      status.full      = (count_ff >= IDX_W'(NODE_CAPACITY));
      status.out_free  = out_free;
      status.pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff;
      status.any_match = any_match_ff;
      status.stall     = stall;
   end

endmodule

// File: hw/rtl/nrps_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search controller
// Sequences request dispatch and the scans of a query over the point memory:
// a first scan and, when a point lies within the radius, a second one.
// ----------------------------------------------------------------------------
module nrps_controller import nrps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DISPATCH = 7'b0000010,
      ST_SCAN1    = 7'b0000100,
      ST_DRAIN1   = 7'b0001000,
      ST_NEAR     = 7'b0010000,
      ST_SCAN2    = 7'b0100000,
      ST_DRAIN2   = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             scan_end;

   assign scan_end = (scan_ff == (status.count - IDX_W'(1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.issue_idx = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            unique case (status.req_type)
               REQ_CLEAR: begin
                  if (status.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_kind = KIND_CLEARED;
                     cmd.do_clear  = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               REQ_INSERT: begin
                  if (status.out_free) begin
                     cmd.emit = 1'b1;
                     if (status.full) begin
                        cmd.emit_kind = KIND_FULL;
                     end else begin
                        cmd.emit_kind = KIND_INSERTED;
                        cmd.do_insert = 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end
               REQ_QUERY: begin
                  if (status.empty) begin
                     if (status.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = KIND_EMPTY;
                        state_in      = ST_IDLE;
                     end
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN1;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN1: begin
            cmd.issue = 1'b1;
            scan_in   = scan_ff + IDX_W'(1);
            if (scan_end) begin
               state_in = ST_DRAIN1;
            end
         end
         ST_DRAIN1: begin
            if (!status.pipe_busy) begin
               state_in = ST_NEAR;
            end
         end
         ST_NEAR: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = KIND_NEAREST;
               scan_in       = '0;
               state_in      = status.any_match ? ST_SCAN2 : ST_IDLE;
            end
         end
         ST_SCAN2: begin
            cmd.pass2 = 1'b1;
            if (!status.stall) begin
               cmd.issue = 1'b1;
               scan_in   = scan_ff + IDX_W'(1);
               if (scan_end) begin
                  state_in = ST_DRAIN2;
               end
            end
         end
         ST_DRAIN2: begin
            cmd.pass2 = 1'b1;
            if (!status.pipe_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/nearest_and_radius_point_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest and radius point search core
// Brute-force nearest and radius search over a table of 2D points.
// ----------------------------------------------------------------------------
// Clear and insert requests pass through the idle and dispatch states. A query
// on n stored points scans the point memory through a four-stage squared
// distance pipeline, one entry per cycle while the result side does not stall:
// the first scan finds the nearest point and the last point within the radius,
// and a second scan, run only when a point lies within the radius, emits one
// word per match. The next request is taken while the final result word still
// waits in the output register. The point memory needs no clearing after reset;
// entries are read only below the current fill count.
module nearest_and_radius_point_search_core import nrps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   nrps_req_if.sink   req_chan,
   nrps_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;

   nrps_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   nrps_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_type      (req_chan.req_type),
      .point_x       (req_chan.point_x),
      .point_y       (req_chan.point_y),
      .search_radius (req_chan.search_radius),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_kind      (rsp_chan.result_kind),
      .rsp_index     (rsp_chan.node_index),
      .rsp_dist      (rsp_chan.sq_distance),
      .rsp_last      (rsp_chan.last)
   );

endmodule

// File: verif/nrps_search_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search checker
// Watches the request and result channels of the point search core. It keeps
// its own copy of the point table, works out the result words that each
// accepted request should cause, and compares every accepted result word with
// the oldest expected word. It reports the number of failures and the number
// of words still expected.
// ----------------------------------------------------------------------------
module nrps_search_checker import nrps_pkg::*; (
   input  logic clock,
   input  logic reset,
   nrps_req_if  req_mon,
   nrps_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [IDX_W-1:0]  index;
      logic [DIST_W-1:0] sq_dist;
      logic              last;
   } search_word_type;

   logic [COORD_BITS-1:0] table_x [NODE_CAPACITY];
   logic [COORD_BITS-1:0] table_y [NODE_CAPACITY];
   int unsigned           table_fill;
   search_word_type       expected_words [$];

   function automatic logic [DIST_W-1:0] squared_distance(
      input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
      input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by);
      logic [COORD_BITS-1:0] dx;
      logic [COORD_BITS-1:0] dy;
      dx = (ax >= bx) ? ax - bx : bx - ax;
      dy = (ay >= by) ? ay - by : by - ay;
      return DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
   endfunction

   function automatic void expect_word(input logic [KIND_W-1:0] kind,
      input logic [IDX_W-1:0] index, input logic [DIST_W-1:0] sq_dist, input logic last);
      search_word_type w;
      w.kind    = kind;
      w.index   = index;
      w.sq_dist = sq_dist;
      w.last    = last;
      expected_words.insert(expected_words.size(), w);
   endfunction

   function automatic void apply_request(input logic [REQ_W-1:0] code,
      input logic [COORD_BITS-1:0] qx, input logic [COORD_BITS-1:0] qy,
      input logic [COORD_BITS-1:0] radius);
      logic [DIST_W-1:0] point_dist [NODE_CAPACITY];
      logic [DIST_W-1:0] reach_sq;
      int                best;
      int                last_hit;
      best      = 0;
      last_hit  = -1;
      reach_sq  = DIST_W'(radius) * DIST_W'(radius);
      case (code)
         REQ_CLEAR: begin
            table_fill = 0;
            expect_word(KIND_CLEARED, '0, '0, 1'b1);
         end
         REQ_INSERT: begin
            if (table_fill >= NODE_CAPACITY) begin
               expect_word(KIND_FULL, '0, '0, 1'b1);
            end else begin
               table_x[table_fill] = qx;
               table_y[table_fill] = qy;
               expect_word(KIND_INSERTED, IDX_W'(table_fill), '0, 1'b1);
               table_fill++;
            end
         end
         REQ_QUERY: begin
            if (table_fill == 0) begin
               expect_word(KIND_EMPTY, '0, '0, 1'b1);
            end else begin
               for (int k = 0; k < int'(table_fill); k++) begin
                  point_dist[k] = squared_distance(qx, qy, table_x[k], table_y[k]);
                  if (point_dist[k] < point_dist[best]) best = k;
                  if (point_dist[k] <= reach_sq) last_hit = k;
               end
               expect_word(KIND_NEAREST, IDX_W'(best), point_dist[best], last_hit < 0);
               for (int k = 0; k < int'(table_fill); k++) begin
                  if (point_dist[k] <= reach_sq)
                     expect_word(KIND_WITHIN, IDX_W'(k), point_dist[k], k == last_hit);
               end
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin : monitor
      search_word_type got;
      search_word_type want;
      if (reset) begin
         table_fill = 0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            apply_request(req_mon.req_type, req_mon.point_x, req_mon.point_y,
                          req_mon.search_radius);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.kind    = rsp_mon.result_kind;
            got.index   = rsp_mon.node_index;
            got.sq_dist = rsp_mon.sq_distance;
            got.last    = rsp_mon.last;
            if (expected_words.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: unexpected result word: kind %0d index %0d dist %0d last %0d",
                           $realtime, got.kind, got.index, got.sq_dist, got.last);
               fail_count = fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind || got.index !== want.index ||
                   got.sq_dist !== want.sq_dist || got.last !== want.last) begin
                  if (fail_count < 10) begin
                     $write("%0t: result word mismatch: expected kind %0d index %0d ",
                            $realtime, want.kind, want.index);
                     $display("dist %0d last %0d, got kind %0d index %0d dist %0d last %0d",
                              want.sq_dist, want.last, got.kind, got.index, got.sq_dist,
                              got.last);
                  end
                  fail_count = fail_count + 1;
               end
            end
         end
      end
      pending_words <= expected_words.size();
   end

endmodule

// File: verif/nearest_and_radius_point_search_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point search core testbench
// Drives clear, insert and query requests into the point search core: a
// directed opening over the coordinate extremes, ties, inclusive radius edges,
// empty and full tables and the unused request code, then random sequences of
// clustered inserts and queries. The sender idles in bursts and the receiver
// stalls on its own pattern. A checker beside the core predicts and compares
// every result word.
// ----------------------------------------------------------------------------
module nearest_and_radius_point_search_core_tb;
   import nrps_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int ITEM_TARGET = 370;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 200;

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY} stall_mode_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_words;
   int   burst_left;
   int   items_sent;
   int   idle_cycles;

   nrps_req_if req_chan ();
   nrps_rsp_if rsp_chan ();

   nearest_and_radius_point_search_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   nrps_search_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      stall_mode_type mode;
      int             run_len;
      rsp_chan.ready = 1'b0;
      forever begin
         mode    = stall_mode_type'($urandom_range(0, 2));
         run_len = $urandom_range(4, 40);
         repeat (run_len) begin
            @(negedge clock);
            case (mode)
               STALL_NONE:   rsp_chan.ready <= 1'b1;
               STALL_RANDOM: rsp_chan.ready <= 1'($urandom_range(0, 1));
               default:      rsp_chan.ready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   task automatic send_request(input logic [REQ_W-1:0] code,
      input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
      input logic [COORD_BITS-1:0] radius);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 12)) begin
            @(negedge clock);
            req_chan.valid         <= 1'b0;
            req_chan.req_type      <= REQ_W'($urandom);
            req_chan.point_x       <= COORD_BITS'($urandom);
            req_chan.point_y       <= COORD_BITS'($urandom);
            req_chan.search_radius <= COORD_BITS'($urandom);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid         <= 1'b1;
      req_chan.req_type      <= code;
      req_chan.point_x       <= x;
      req_chan.point_y       <= y;
      req_chan.search_radius <= radius;
      do @(posedge clock); while (!req_chan.ready);
      if (code != REQ_UNKNOWN) items_sent++;
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   initial begin
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [COORD_BITS-1:0] spread;
      logic [COORD_BITS-1:0] radius;
      int                    fill_est;
      int                    n_insert;
      int                    n_query;

      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.req_type      = REQ_CLEAR;
      req_chan.point_x       = '0;
      req_chan.point_y       = '0;
      req_chan.search_radius = '0;
      burst_left             = 0;
      items_sent             = 0;
      fill_est               = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Opening: empty table, coordinate corners, ties and inclusive radius edges.
      send_request(REQ_QUERY,  16'h0100, 16'h0100, 16'hFFFF);
      send_request(REQ_INSERT, 16'h0000, 16'h0000, 16'h0000);
      send_request(REQ_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_INSERT, 16'hFFFF, 16'h0000, 16'h0000);
      send_request(REQ_INSERT, 16'h0000, 16'hFFFF, 16'h0000);
      send_request(REQ_INSERT, 16'h0000, 16'h0000, 16'hFFFF);
      send_request(REQ_QUERY,  16'h0000, 16'h0000, 16'h0000);
      send_request(REQ_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_QUERY,  16'h0000, 16'h0000, 16'hFFFF);
      send_request(REQ_QUERY,  16'h8000, 16'h8000, 16'h0000);
      send_request(REQ_UNKNOWN, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(REQ_INSERT, 16'hAAAA, 16'h5555, 16'h0000);
      send_request(REQ_INSERT, 16'h5555, 16'hAAAA, 16'h0000);
      send_request(REQ_QUERY,  16'h5555, 16'h5555, 16'h5555);
      send_request(REQ_CLEAR,  16'h0000, 16'h0000, 16'h0000);
      send_request(REQ_QUERY,  16'h1234, 16'h5678, 16'h0001);
      send_request(REQ_INSERT, 16'h0001, 16'h0002, 16'h0000);
      send_request(REQ_QUERY,  16'h0001, 16'h0002, 16'hFFFF);
      send_request(REQ_CLEAR,  16'h0000, 16'h0000, 16'h0000);
      hold_until_drained();

      // Fill the table past capacity once so the full case and the longest
      // queries are seen early.
      for (int k = 0; k < NODE_CAPACITY + 2; k++)
         send_request(REQ_INSERT, COORD_BITS'($urandom), COORD_BITS'($urandom), '0);
      send_request(REQ_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom), 16'hFFFF);
      send_request(REQ_QUERY, COORD_BITS'($urandom), COORD_BITS'($urandom),
                   COORD_BITS'($urandom));
      fill_est = NODE_CAPACITY;

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 3) != 0) begin
            send_request(REQ_CLEAR, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         COORD_BITS'($urandom));
            fill_est = 0;
         end
         case ($urandom_range(0, 2))
            0:       spread = COORD_BITS'(3);
            1:       spread = COORD_BITS'(8'hFF);
            default: spread = '1;
         endcase
         cx = COORD_BITS'($urandom);
         cy = COORD_BITS'($urandom);
         if ($urandom_range(0, 9) == 0)
            n_insert = NODE_CAPACITY - fill_est + $urandom_range(0, 2);
         else
            n_insert = $urandom_range(0, 6);
         for (int k = 0; k < n_insert; k++) begin
            if ($urandom_range(0, 19) == 0)
               send_request(REQ_UNKNOWN, COORD_BITS'($urandom), COORD_BITS'($urandom),
                            COORD_BITS'($urandom));
            send_request(REQ_INSERT, cx + (COORD_BITS'($urandom) & spread),
                         cy + (COORD_BITS'($urandom) & spread), COORD_BITS'($urandom));
            if (fill_est < NODE_CAPACITY) fill_est++;
         end
         n_query = $urandom_range(1, 5);
         for (int k = 0; k < n_query; k++) begin
            case ($urandom_range(0, 4))
               0:       radius = '0;
               1:       radius = COORD_BITS'($urandom_range(0, 8));
               2:       radius = COORD_BITS'($urandom) & spread;
               3:       radius = '1;
               default: radius = COORD_BITS'($urandom);
            endcase
            send_request(REQ_QUERY, cx + (COORD_BITS'($urandom) & spread),
                         cy + (COORD_BITS'($urandom) & spread), radius);
         end
         if ($urandom_range(0, 5) == 0) hold_until_drained();
      end

      hold_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_words == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
